// ----- sv/gfm_pkg.sv -----
package gfm_pkg;

    localparam int WORD_W     = 64;
    localparam int ELEM_W     = 2 * WORD_W;
    // b bits folded in per pipeline stage
    localparam int DIGIT_W    = 16;
    localparam int NUM_STAGES = ELEM_W / DIGIT_W;

    // x^128 = x^7 + x^2 + x + 1 (mod P)
    localparam logic [7:0] POLY_LOW = 8'h87;

    typedef struct packed {
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;    // unconsumed digits, next digit at the top
        logic [ELEM_W-1:0] acc;
    } gfm_data_t;

    // One Horner step: acc * x^DIGIT_W + a * digit, reduced mod P.
    // Overflow is below x^(128+DIGIT_W), so a single fold suffices.
    function automatic logic [ELEM_W-1:0] gfm_step(
        input logic [ELEM_W-1:0]  acc,
        input logic [ELEM_W-1:0]  a,
        input logic [DIGIT_W-1:0] digit
    );
        logic [ELEM_W+DIGIT_W-1:0] wide;
        logic [DIGIT_W-1:0]        ovf;
        logic [ELEM_W-1:0]         fold;
        wide = {acc, {DIGIT_W{1'b0}}};
        for (int j = 0; j < DIGIT_W; j++)
        begin
            if (digit[j])
            begin
                wide = wide ^ ({{DIGIT_W{1'b0}}, a} << j);
            end
        end
        ovf  = wide[ELEM_W+DIGIT_W-1 -: DIGIT_W];
        fold = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (POLY_LOW[i])
            begin
                fold = fold ^ ({{(ELEM_W-DIGIT_W){1'b0}}, ovf} << i);
            end
        end
        return wide[ELEM_W-1:0] ^ fold;
    endfunction

endpackage

// ----- sv/gfm_in_if.sv -----
interface gfm_in_if;

    logic                       valid;
    logic                       ready;
    logic [gfm_pkg::WORD_W-1:0] a_hi;
    logic [gfm_pkg::WORD_W-1:0] a_lo;
    logic [gfm_pkg::WORD_W-1:0] b_hi;
    logic [gfm_pkg::WORD_W-1:0] b_lo;

    modport source (output valid, output a_hi, output a_lo, output b_hi, output b_lo,
                    input ready);
    modport sink   (input valid, input a_hi, input a_lo, input b_hi, input b_lo,
                    output ready);

endinterface

// ----- sv/gfm_out_if.sv -----
interface gfm_out_if;

    logic                       valid;
    logic                       ready;
    logic [gfm_pkg::WORD_W-1:0] prod_hi;
    logic [gfm_pkg::WORD_W-1:0] prod_lo;

    modport source (output valid, output prod_hi, output prod_lo, input ready);
    modport sink   (input valid, input prod_hi, input prod_lo, output ready);

endinterface

// ----- sv/gfm_stage.sv -----
module gfm_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gfm_pkg::gfm_data_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output gfm_pkg::gfm_data_t out_data
);
    import gfm_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    gfm_data_t data_reg;
    gfm_data_t data_next;

    // stage takes a word when empty or when its word leaves this cycle
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next.a   = in_data.a;
        data_next.b   = in_data.b << DIGIT_W;
        data_next.acc = gfm_step(in_data.acc, in_data.a, in_data.b[ELEM_W-1 -: DIGIT_W]);
        valid_next    = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- sv/gf128_multiply_unit.sv -----
// channel   dir  interface    payload
// operand   in   gfm_in_if    a_hi, a_lo, b_hi, b_lo  (64 b each)
// product   out  gfm_out_if   prod_hi, prod_lo        (64 b each)
//
// One word per cycle sustained while product is ready; 8 register stages.
// Eight stages each fold 16 bits of b (MSB first) into the accumulator and reduce.
// Reset clears the stage valid bits only; no clearing pass.
// A stall on product holds each full stage whose following stages are all full; words move on into empty stages.
module gf128_multiply_unit (
    input logic         clk,
    input logic         rst_n,
    gfm_in_if.sink      operand,
    gfm_out_if.source   product
);
    import gfm_pkg::*;

    logic      stg_valid [0:NUM_STAGES];
    logic      stg_ready [0:NUM_STAGES];
    gfm_data_t stg_data  [0:NUM_STAGES];

    assign stg_valid[0]     = operand.valid;
    assign operand.ready    = stg_ready[0];
    assign stg_data[0].a    = {operand.a_hi, operand.a_lo};
    assign stg_data[0].b    = {operand.b_hi, operand.b_lo};
    assign stg_data[0].acc  = '0;

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        gfm_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[s]),
            .in_ready  (stg_ready[s]),
            .in_data   (stg_data[s]),
            .out_valid (stg_valid[s+1]),
            .out_ready (stg_ready[s+1]),
            .out_data  (stg_data[s+1])
        );
    end

    assign product.valid        = stg_valid[NUM_STAGES];
    assign stg_ready[NUM_STAGES] = product.ready;
    assign product.prod_hi      = stg_data[NUM_STAGES].acc[ELEM_W-1 -: WORD_W];
    assign product.prod_lo      = stg_data[NUM_STAGES].acc[WORD_W-1:0];

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

class gf_product_board;

    localparam int ELEM_W = gfm_pkg::ELEM_W;
    localparam int WORD_W = gfm_pkg::WORD_W;
    // x^128 folds back onto x^7 + x^2 + x + 1
    localparam logic [7:0] REDUCE_TERMS = 8'h87;

    logic [ELEM_W-1:0] expected_q[$];
    int                errors;

    function new();
        errors = 0;
    endfunction

    // MSB-first shift-and-add over b, reducing each overflow of x^127
    function logic [ELEM_W-1:0] field_product(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
        logic [ELEM_W-1:0] acc;
        logic              carry;
        acc = '0;
        for (int i = ELEM_W - 1; i >= 0; i--)
        begin
            carry = acc[ELEM_W-1];
            acc   = acc << 1;
            if (carry)
            begin
                acc[7:0] = acc[7:0] ^ REDUCE_TERMS;
            end
            if (b[i])
            begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

    function void note_operand(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
        expected_q.push_back(field_product(a, b));
    endfunction

    function void check_product(logic [WORD_W-1:0] hi, logic [WORD_W-1:0] lo);
        logic [ELEM_W-1:0] want;
        if (expected_q.size() == 0)
        begin
            $error("product word with none pending: prod_hi=%h prod_lo=%h", hi, lo);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (hi !== want[ELEM_W-1:WORD_W])
        begin
            $error("prod_hi: expected %h, actual %h", want[ELEM_W-1:WORD_W], hi);
            errors++;
        end
        if (lo !== want[WORD_W-1:0])
        begin
            $error("prod_lo: expected %h, actual %h", want[WORD_W-1:0], lo);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

endclass

module tb_top;

    localparam int ELEM_W          = gfm_pkg::ELEM_W;
    localparam int WORD_W          = gfm_pkg::WORD_W;
    localparam int RANDOM_ITEMS    = 1400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 24;

    localparam logic [ELEM_W-1:0] ELEM_ONE = 128'h1;
    localparam logic [ELEM_W-1:0] ELEM_ALL = '1;
    localparam logic [ELEM_W-1:0] ELEM_TOP = 128'h1 << (ELEM_W - 1);

    logic clk = 1'b0;
    logic rst_n;

    bit no_idle      = 1'b0;
    bit hold_off_req = 1'b0;

    gf_product_board board = new();

    gfm_in_if  operand_if();
    gfm_out_if product_if();

    gf128_multiply_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_if),
        .product (product_if)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [ELEM_W-1:0] rand_full();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [ELEM_W-1:0] rand_elem();
        int r;
        r = $urandom_range(9);
        case (r)
            7: return ELEM_ONE << $urandom_range(ELEM_W - 1);
            8: return rand_full() & rand_full() & rand_full();
            9:
            begin
                case ($urandom_range(2))
                    0: return '0;
                    1: return ELEM_ONE;
                    default: return ELEM_ALL;
                endcase
            end
            default: return rand_full();
        endcase
    endfunction

    // returns right after the accepting rising edge
    task automatic send_operand(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b);
        int gap;
        gap = idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            operand_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        operand_if.valid <= 1'b1;
        operand_if.a_hi  <= a[ELEM_W-1:WORD_W];
        operand_if.a_lo  <= a[WORD_W-1:0];
        operand_if.b_hi  <= b[ELEM_W-1:WORD_W];
        operand_if.b_lo  <= b[WORD_W-1:0];
        do
            @(posedge clk);
        while (operand_if.ready !== 1'b1);
        board.note_operand(a, b);
    endtask

    always @(posedge clk)
    begin
        if (product_if.valid === 1'b1 && product_if.ready === 1'b1)
        begin
            board.check_product(product_if.prod_hi, product_if.prod_lo);
        end
    end

    // product side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall_left;
        int gap;
        stall_left = 0;
        product_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                product_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                product_if.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                product_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                gap = idle_gap();
                product_if.ready <= (gap == 0);
                if (gap > 0)
                begin
                    stall_left = gap - 1;
                end
            end
        end
    end

    initial
    begin
        logic [ELEM_W-1:0] r;
        rst_n            = 1'b0;
        operand_if.valid = 1'b0;
        operand_if.a_hi  = '0;
        operand_if.a_lo  = '0;
        operand_if.b_hi  = '0;
        operand_if.b_lo  = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        r = rand_full();
        send_operand('0, r);
        send_operand(r, '0);
        send_operand('0, '0);
        send_operand(ELEM_ONE, r);
        send_operand(r, ELEM_ONE);
        send_operand(ELEM_ONE, ELEM_ONE);
        send_operand(ELEM_ALL, ELEM_ALL);
        send_operand(ELEM_ALL, ELEM_ONE);
        // x^127 * x wraps straight into the low terms
        send_operand(ELEM_TOP, 128'h2);
        send_operand(128'h2, ELEM_TOP);
        send_operand(ELEM_TOP, ELEM_TOP);
        send_operand(ELEM_ALL, ELEM_TOP);
        send_operand({{WORD_W{1'b1}}, {WORD_W{1'b0}}}, {{WORD_W{1'b0}}, {WORD_W{1'b1}}});
        send_operand({8{16'h5555}}, {8{16'hAAAA}});
        send_operand({8{16'hAAAA}}, {8{16'h5555}});
        send_operand(ELEM_ALL, '0);
        send_operand('0, ELEM_ALL);
        send_operand(rand_full(), rand_full());

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 300)
            begin
                // stall the product side and keep offering words
                hold_off_req = 1'b1;
                no_idle      = 1'b1;
            end
            else if (i == 340)
            begin
                no_idle = 1'b0;
            end
            else if (i % 200 == 100)
            begin
                no_idle = 1'b1;
            end
            else if (i % 200 == 180)
            begin
                no_idle = 1'b0;
            end
            send_operand(rand_elem(), rand_elem());
        end
        no_idle = 1'b0;
        @(negedge clk);
        operand_if.valid <= 1'b0;

        while (board.pending() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
